// File: hw/rtl/cnc_pkg.sv
`timescale 1ns / 1ps

package cnc_pkg;

    localparam int MAP_WORDS_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int WORD_W  = 64;
    localparam int CNT_W   = 7;
    localparam int TOTAL_W = 17;
    localparam int DEPTH_W = 8;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // SWAR population count masks
    localparam logic [WORD_W-1:0] POP_M1 = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] POP_M2 = 64'h3333_3333_3333_3333;
    localparam logic [WORD_W-1:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT   = 1'b1;

    localparam logic [DEPTH_W-1:0] CURRENT_DEPTH_RST = 8'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST   = 8'd8;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] trace_word;
        logic              last_word;
    } trace_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]   new_in_word;
        logic               found_new;
        logic [TOTAL_W-1:0] total_points;
        logic               run_done;
    } result_t;

endpackage

// File: hw/rtl/cnc_map_mem.sv
`timescale 1ns / 1ps

module cnc_map_mem
    import cnc_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [MAP_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/cnc_popcnt_bytes.sv
`timescale 1ns / 1ps

module cnc_popcnt_bytes
    import cnc_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] byte_counts
);

    logic [WORD_W-1:0] pairs;
    logic [WORD_W-1:0] nibbles;

    // each output byte holds the count of its own byte, 0..8
    always_comb
    begin
        pairs       = word - ((word >> 1) & POP_M1);
        nibbles     = (pairs & POP_M2) + ((pairs >> 2) & POP_M2);
        byte_counts = (nibbles + (nibbles >> 4)) & POP_M4;
    end

endmodule

// File: hw/rtl/coverage_novelty_check.sv
`timescale 1ns / 1ps

// Coverage novelty check. Each request carries one 64-bit trace word and its
// map index; the block ORs it into a cumulative coverage map held in a
// single-port-read, single-port-write RAM and returns one result per request
// with the count of newly covered bits, the sticky run flag, the saturating
// total and the end-of-run mark. Requests are handled one at a time: a
// request passes through the map read, the popcount of the fresh bits with
// the write-back, and the byte sum with the total update before the next
// is taken; a stalled result holds the next request back. After reset the
// map is cleared one word a cycle, and trace_stall stays high until the
// whole map is clear; configuration writes are taken throughout. Checking
// is off while current_depth >= depth_limit.
module coverage_novelty_check
    import cnc_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 trace_valid,
    output logic                 trace_stall,
    input  trace_req_t           trace,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEPTH_W-1:0]   cfg_wdata
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WIDE_W = 17;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [WIDE_W-1:0] MAP_WORDS_W = WIDE_W'(MAP_WORDS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    trace_req_t         item_reg;
    logic               in_range_reg;
    logic [WORD_W-1:0]  counts_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               run_found_reg, run_found_next;
    logic [DEPTH_W-1:0] current_depth_reg;
    logic [DEPTH_W-1:0] depth_limit_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic               accept;
    logic               enabled;
    logic [WIDE_W-1:0]  idx_wide;
    logic [WIDE_W-1:0]  item_idx_wide;
    logic [AW-1:0]      rd_addr;
    logic               in_range;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  fresh;
    logic [WORD_W-1:0]  byte_counts;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [CNT_W-1:0]   added;
    logic [TOTAL_W:0]   sum_wide;
    logic               found_now;
    logic               out_free;

    assign trace_stall = (state_reg != ST_IDLE);
    assign accept      = trace_valid && !trace_stall;
    assign enabled     = (current_depth_reg < depth_limit_reg);

    assign idx_wide = {{(WIDE_W - IDX_W){1'b0}}, trace.word_index};
    assign rd_addr  = idx_wide[AW-1:0];
    assign in_range = (idx_wide < MAP_WORDS_W);

    assign item_idx_wide = {{(WIDE_W - IDX_W){1'b0}}, item_reg.word_index};

    cnc_map_mem #(
        .MAP_WORDS (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // out-of-range index matches nothing
    assign fresh = in_range_reg ? (item_reg.trace_word & ~rd_data) : '0;

    cnc_popcnt_bytes u_pop (
        .word        (fresh),
        .byte_counts (byte_counts)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_READ)
        begin
            wr_en   = enabled && in_range_reg;
            wr_addr = item_idx_wide[AW-1:0];
            wr_data = rd_data | item_reg.trace_word;
        end
    end

    always_comb
    begin
        added = '0;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            added = added + CNT_W'(counts_reg[i*8 +: 4]);
        end
    end

    assign sum_wide  = {1'b0, total_reg} + {{(TOTAL_W + 1 - CNT_W){1'b0}}, added};
    assign found_now = run_found_reg || (added != '0);
    assign out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        total_next     = total_reg;
        run_found_next = run_found_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next.run_done = item_reg.last_word;
                    if (enabled)
                    begin
                        total_next = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
                        out_data_next.new_in_word  = added;
                        out_data_next.found_new    = found_now;
                        out_data_next.total_points = total_next;
                        run_found_next             = found_now;
                    end
                    else
                    begin
                        out_data_next.new_in_word  = '0;
                        out_data_next.found_new    = 1'b0;
                        out_data_next.total_points = total_reg;
                    end
                    if (item_reg.last_word)
                    begin
                        run_found_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            total_reg         <= '0;
            run_found_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            current_depth_reg <= CURRENT_DEPTH_RST;
            depth_limit_reg   <= DEPTH_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            total_reg     <= total_next;
            run_found_reg <= run_found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CURRENT_DEPTH: current_depth_reg <= cfg_wdata;
                    CFG_DEPTH_LIMIT:   depth_limit_reg   <= cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= trace;
            in_range_reg <= in_range;
        end
        if (state_reg == ST_READ)
        begin
            counts_reg <= byte_counts;
        end
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule
